### rtl/sdam_pkg.sv
`default_nettype none

package sdam_pkg;

  localparam int unsigned IN_DIG_W  = 32;
  localparam int unsigned OUT_DIG_W = 64;
  localparam int unsigned LEN_W     = 5;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_MUL = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic [IN_DIG_W-1:0] a_digits;
    logic                a_neg;
    logic [IN_DIG_W-1:0] b_digits;
    logic                b_neg;
  } in_t;

  typedef struct packed {
    logic [OUT_DIG_W-1:0] result_digits;
    logic                 result_neg;
    logic [LEN_W-1:0]     result_length;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic conv_step;
    logic arith;
    logic wrap_step;
    logic dabble_step;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic wrap_done;
  } dp_sts_t;

  // Largest binary value of n nibbles when every nibble reads as fifteen
  function automatic longint unsigned op_max(input int unsigned n);
    longint unsigned v;
    v = 0;
    for (int unsigned i = 0; i < n; i++) begin
      v = v * 10 + 15;
    end
    return v;
  endfunction

  function automatic longint unsigned pow10(input int unsigned n);
    longint unsigned v;
    v = 1;
    for (int unsigned i = 0; i < n; i++) begin
      v = v * 10;
    end
    return v;
  endfunction

  function automatic int unsigned op_width(input int unsigned n);
    return $clog2(op_max(n) + 1);
  endfunction

endpackage

`default_nettype wire

### rtl/sdam_datapath.sv
`default_nettype none

module sdam_datapath import sdam_pkg::*; #(
  parameter int unsigned DIGITS = 8
) (
  input  wire logic    clk_i,
  input  wire dp_cmd_t cmd_i,
  output dp_sts_t      sts_o,
  input  wire in_t     in_data_i,
  output out_t         out_data_o
);

  localparam int unsigned NIB_W   = 4 * DIGITS;
  localparam int unsigned OPW     = op_width(DIGITS);
  localparam int unsigned PW      = 2 * OPW;
  localparam int unsigned RES_DIG = 2 * DIGITS;
  localparam int unsigned RES_W   = 4 * RES_DIG;
  localparam logic [PW-1:0] MOD_P = PW'(pow10(RES_DIG));

  logic [NIB_W-1:0] a_sh_q, b_sh_q;
  logic [OPW-1:0]   a_val_q, b_val_q;
  logic             mul_q, an_q, bn_q, neg_q;
  logic [PW-1:0]    bin_q;
  logic [RES_W-1:0] bcd_q, bcd_adj;
  out_t             out_q;
  logic [LEN_W-1:0] len;
  logic             bcd_nz;

  assign sts_o.wrap_done = (bin_q < MOD_P);
  assign out_data_o      = out_q;
  assign bcd_nz          = |bcd_q;

  // add three to every digit of five or more ahead of the shift
  always_comb begin
    for (int unsigned i = 0; i < RES_DIG; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                     : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    len = LEN_W'(1);
    for (int unsigned i = 0; i < RES_DIG; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        len = LEN_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_sh_q  <= in_data_i.a_digits[NIB_W-1:0];
      b_sh_q  <= in_data_i.b_digits[NIB_W-1:0];
      a_val_q <= '0;
      b_val_q <= '0;
      mul_q   <= (in_data_i.cmd == CMD_MUL);
      an_q    <= in_data_i.a_neg;
      bn_q    <= in_data_i.b_neg;
    end
    if (cmd_i.conv_step) begin
      // most significant digit first: value = value * 10 + digit
      a_val_q <= (a_val_q << 3) + (a_val_q << 1) + OPW'(a_sh_q[NIB_W-1 -: 4]);
      b_val_q <= (b_val_q << 3) + (b_val_q << 1) + OPW'(b_sh_q[NIB_W-1 -: 4]);
      a_sh_q  <= a_sh_q << 4;
      b_sh_q  <= b_sh_q << 4;
    end
    if (cmd_i.arith) begin
      bcd_q <= '0;
      if (mul_q) begin
        bin_q <= PW'(a_val_q) * PW'(b_val_q);
        neg_q <= an_q ^ bn_q;
      end else if (an_q == bn_q) begin
        bin_q <= PW'(a_val_q) + PW'(b_val_q);
        neg_q <= an_q;
      end else if (a_val_q >= b_val_q) begin
        bin_q <= PW'(a_val_q - b_val_q);
        neg_q <= an_q;
      end else begin
        bin_q <= PW'(b_val_q - a_val_q);
        neg_q <= bn_q;
      end
    end
    if (cmd_i.wrap_step) begin
      bin_q <= bin_q - MOD_P;
    end
    if (cmd_i.dabble_step) begin
      bcd_q <= {bcd_adj[RES_W-2:0], bin_q[PW-1]};
      bin_q <= bin_q << 1;
    end
    if (cmd_i.out_load) begin
      out_q.result_digits <= OUT_DIG_W'(bcd_q);
      out_q.result_neg    <= neg_q & bcd_nz;
      out_q.result_length <= len;
    end
  end

endmodule

`default_nettype wire

### rtl/sdam_ctrl.sv
`default_nettype none

module sdam_ctrl import sdam_pkg::*; #(
  parameter int unsigned DIGITS = 8
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output dp_cmd_t      cmd_o,
  input  wire dp_sts_t sts_i
);

  localparam int unsigned PW    = 2 * op_width(DIGITS);
  localparam int unsigned CNT_W = $clog2(PW + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CONV   = 3'd1;
  localparam logic [2:0] S_ARITH  = 3'd2;
  localparam logic [2:0] S_WRAP   = 3'd3;
  localparam logic [2:0] S_DABBLE = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = CNT_W'(DIGITS);
          state_d    = S_CONV;
        end
      end
      S_CONV: begin
        cmd_o.conv_step = 1'b1;
        cnt_d           = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = S_ARITH;
        end
      end
      S_ARITH: begin
        cmd_o.arith = 1'b1;
        state_d     = S_WRAP;
      end
      S_WRAP: begin
        if (sts_i.wrap_done) begin
          cnt_d   = CNT_W'(PW);
          state_d = S_DABBLE;
        end else begin
          cmd_o.wrap_step = 1'b1;
        end
      end
      S_DABBLE: begin
        cmd_o.dabble_step = 1'b1;
        cnt_d             = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### rtl/signed_decimal_add_multiply.sv
// Signed-magnitude BCD add and multiply. One request at a time: after a
// request is taken, in_ready_o stays low until its result has been moved
// into the output register. A request goes through decimal to binary
// conversion (one digit a cycle), add, subtract or multiply, repeated
// subtraction for reduction modulo 10^(2*DIGITS), and shift-and-add-three
// conversion of the 2*ceil(log2(15*(10^DIGITS-1)/9+1))-bit binary result
// back to BCD, one bit a cycle. The result register lets the next request
// start while the previous result waits to be taken. Digits above nine are
// taken at face value times their weight; a zero result is always positive
// with a length of one.
`default_nettype none

module signed_decimal_add_multiply import sdam_pkg::*; #(
  parameter int unsigned DIGITS = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  sdam_ctrl #(
    .DIGITS(DIGITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (dp_cmd),
    .sts_i      (dp_sts)
  );

  sdam_datapath #(
    .DIGITS(DIGITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .cmd_i     (dp_cmd),
    .sts_o     (dp_sts),
    .in_data_i (in_data_i),
    .out_data_o(out_data_o)
  );

endmodule

`default_nettype wire

### rtl/sdam_checker.sv
`default_nettype none

module sdam_checker import sdam_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire in_t  in_data_i,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_t out_data_o
);

  // one request in flight: the input side closes right after a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again straight after a request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result dropped or changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_neg |-> out_data_o.result_digits != '0)
    else $error("negative zero result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_digits == '0 |-> out_data_o.result_length == LEN_W'(1))
    else $error("zero result with length other than one");

endmodule

bind signed_decimal_add_multiply sdam_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire
